@@ src/cbm_pkg.sv @@
// Shared types and constants for the cartridge bank mapper with IRQ counter.
`default_nettype none
package cbm_pkg;

	typedef enum logic [1:0] {
		OP_CPU_WRITE = 2'd0,
		OP_CPU_TICK  = 2'd1,
		OP_PPU_CYCLE = 2'd2,
		OP_LOOKUP    = 2'd3
	} op_t;

	// CPU register window, selected by address bits 14:13
	typedef enum logic [1:0] {
		RGN_BANK   = 2'd0,
		RGN_MIRROR = 2'd1,
		RGN_IRQ    = 2'd2,
		RGN_ACK    = 2'd3
	} region_t;

	// bank select field of the command register; other codes write nothing
	typedef enum logic [3:0] {
		SEL_CHR0 = 4'd0,
		SEL_CHR2 = 4'd1,
		SEL_CHR4 = 4'd2,
		SEL_CHR5 = 4'd3,
		SEL_CHR6 = 4'd4,
		SEL_CHR7 = 4'd5,
		SEL_PRG0 = 4'd6,
		SEL_PRG1 = 4'd7,
		SEL_CHR1 = 4'd8,
		SEL_CHR3 = 4'd9,
		SEL_PRG2 = 4'd15
	} sel_t;

	localparam int CMD_CHR_INV_BIT  = 7;
	localparam int CMD_PRG_SWAP_BIT = 6;
	localparam int CMD_CHR_1K_BIT   = 5;
	localparam int PPU_A12_BIT      = 12;

	localparam logic [2:0] PRESCALE_RELOAD = 3'd4;
	localparam logic [2:0] ASSERT_DELAY    = 3'd4;
	localparam logic [3:0] A12_HOLD        = 4'd8;
	localparam logic [7:0] PRG_LAST_BANK   = 8'hFF;

	typedef struct packed {
		logic       irq_asserted;
		logic [7:0] prg_bank;
		logic [7:0] chr_bank;
		logic       mirror_horizontal;
	} res_t;

endpackage
`default_nettype wire

@@ src/cbm_core.sv @@
// Mapper register file, IRQ counter and bank lookup for one beat.
`default_nettype none
module cbm_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          fire,
	input  wire logic [1:0]    op,
	input  wire logic [15:0]   address,
	input  wire logic [7:0]    data,
	input  wire logic          rendering,
	output cbm_pkg::res_t      res
);

	logic [7:0] cmd_q, cmd_n;
	logic [7:0] prg_q [3];
	logic [7:0] prg_n [3];
	logic [7:0] chr_q [8];
	logic [7:0] chr_n [8];
	logic       mirror_q, mirror_n;
	logic       en_q, en_n;
	logic [7:0] cnt_q, cnt_n;
	logic [7:0] rld_q, rld_n;
	logic       rpend_q, rpend_n;
	logic       mode_q, mode_n;
	logic [3:0] filt_q, filt_n;
	logic [2:0] pre_q, pre_n;
	logic [2:0] dly_q, dly_n;
	logic       line_q, line_n;

	logic       cnt_clk;
	logic [2:0] pre_dec;
	logic [2:0] chr_idx;
	logic [2:0] chr_rd;
	logic [7:0] chr_word;
	logic [1:0] prg_rd;

	cbm_pkg::op_t     op_c;
	cbm_pkg::region_t rgn;

	assign op_c    = cbm_pkg::op_t'(op);
	assign rgn     = cbm_pkg::region_t'(address[14:13]);
	assign pre_dec = pre_q - 3'd1;

	always_comb begin
		cmd_n    = cmd_q;
		prg_n    = prg_q;
		chr_n    = chr_q;
		mirror_n = mirror_q;
		en_n     = en_q;
		cnt_n    = cnt_q;
		rld_n    = rld_q;
		rpend_n  = rpend_q;
		mode_n   = mode_q;
		filt_n   = filt_q;
		pre_n    = pre_q;
		dly_n    = dly_q;
		line_n   = line_q;
		cnt_clk  = 1'b0;
		unique case (op_c)
			cbm_pkg::OP_CPU_WRITE: begin
				if (address[15]) begin
					unique case (rgn)
						cbm_pkg::RGN_BANK: begin
							if (!address[0]) begin
								cmd_n = data;
							end else begin
								case (cbm_pkg::sel_t'(cmd_q[3:0]))
									cbm_pkg::SEL_CHR0: chr_n[0] = data;
									cbm_pkg::SEL_CHR2: chr_n[2] = data;
									cbm_pkg::SEL_CHR4: chr_n[4] = data;
									cbm_pkg::SEL_CHR5: chr_n[5] = data;
									cbm_pkg::SEL_CHR6: chr_n[6] = data;
									cbm_pkg::SEL_CHR7: chr_n[7] = data;
									cbm_pkg::SEL_PRG0: prg_n[0] = data;
									cbm_pkg::SEL_PRG1: prg_n[1] = data;
									cbm_pkg::SEL_CHR1: chr_n[1] = data;
									cbm_pkg::SEL_CHR3: chr_n[3] = data;
									cbm_pkg::SEL_PRG2: prg_n[2] = data;
									default: ;
								endcase
							end
						end
						cbm_pkg::RGN_MIRROR: begin
							if (!address[0]) mirror_n = data[0];
						end
						cbm_pkg::RGN_IRQ: begin
							if (address[0]) begin
								mode_n  = data[0];
								rpend_n = 1'b1;
								pre_n   = data[0] ? cbm_pkg::PRESCALE_RELOAD : 3'd0;
							end else begin
								rld_n = data;
							end
						end
						cbm_pkg::RGN_ACK: begin
							en_n   = address[0];
							line_n = 1'b0;
						end
						default: ;
					endcase
				end
			end
			cbm_pkg::OP_PPU_CYCLE: begin
				if (!mode_q && rendering) begin
					if (filt_q != 4'd0) filt_n = filt_q - 4'd1;
					if (address[cbm_pkg::PPU_A12_BIT]) begin
						if (filt_n == 4'd0) pre_n = 3'd1;
						filt_n = cbm_pkg::A12_HOLD;
					end
				end
			end
			cbm_pkg::OP_CPU_TICK: begin
				if (mode_q) begin
					pre_n = pre_dec;
					if (pre_dec == 3'd0) begin
						cnt_clk = 1'b1;
						pre_n   = cbm_pkg::PRESCALE_RELOAD;
					end
				end else if (pre_q != 3'd0) begin
					pre_n = pre_dec;
					if (pre_dec == 3'd0) cnt_clk = 1'b1;
				end
				if (cnt_clk) begin
					if (rpend_q) begin
						rpend_n = 1'b0;
						cnt_n   = {rld_q[7:1], rld_q[0] | (rld_q != 8'd0)};
					end else if (cnt_q == 8'd0) begin
						cnt_n = rld_q;
					end else begin
						cnt_n = cnt_q - 8'd1;
					end
					if (en_q && cnt_n == 8'd0) dly_n = cbm_pkg::ASSERT_DELAY;
				end
				if (dly_n != 3'd0) begin
					dly_n = dly_n - 3'd1;
					if (dly_n == 3'd0) line_n = 1'b1;
				end
			end
			cbm_pkg::OP_LOOKUP: ;
			default: ;
		endcase
	end

	// lookups see the state after this beat's update
	always_comb begin
		chr_idx = address[12:10] ^ {cmd_n[cbm_pkg::CMD_CHR_INV_BIT], 2'b00};
		chr_rd  = (cmd_n[cbm_pkg::CMD_CHR_1K_BIT] || chr_idx[2]) ?
			chr_idx : {1'b0, chr_idx[1], 1'b0};
		chr_word = chr_n[chr_rd];
		if (!(cmd_n[cbm_pkg::CMD_CHR_1K_BIT] || chr_idx[2]))
			chr_word = {chr_word[7:1], chr_idx[0]};
		unique case (address[14:13])
			2'd0:    prg_rd = cmd_n[cbm_pkg::CMD_PRG_SWAP_BIT] ? 2'd2 : 2'd0;
			2'd1:    prg_rd = 2'd1;
			2'd2:    prg_rd = cmd_n[cbm_pkg::CMD_PRG_SWAP_BIT] ? 2'd0 : 2'd2;
			default: prg_rd = 2'd3;
		endcase
		res.irq_asserted      = line_n;
		res.mirror_horizontal = mirror_n;
		if (!address[15])
			res.prg_bank = 8'd0;
		else if (prg_rd == 2'd3)
			res.prg_bank = cbm_pkg::PRG_LAST_BANK;
		else
			res.prg_bank = prg_n[prg_rd];
		res.chr_bank = (address[15:13] != 3'd0) ? 8'd0 : chr_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q    <= 8'd0;
			for (int i = 0; i < 3; i++) prg_q[i] <= cbm_pkg::PRG_LAST_BANK;
			for (int i = 0; i < 8; i++) chr_q[i] <= 8'(i);
			mirror_q <= 1'b0;
			en_q     <= 1'b0;
			cnt_q    <= 8'd0;
			rld_q    <= 8'd0;
			rpend_q  <= 1'b0;
			mode_q   <= 1'b0;
			filt_q   <= 4'd0;
			pre_q    <= 3'd0;
			dly_q    <= 3'd0;
			line_q   <= 1'b0;
		end else if (fire) begin
			cmd_q    <= cmd_n;
			prg_q    <= prg_n;
			chr_q    <= chr_n;
			mirror_q <= mirror_n;
			en_q     <= en_n;
			cnt_q    <= cnt_n;
			rld_q    <= rld_n;
			rpend_q  <= rpend_n;
			mode_q   <= mode_n;
			filt_q   <= filt_n;
			pre_q    <= pre_n;
			dly_q    <= dly_n;
			line_q   <= line_n;
		end
	end

endmodule
`default_nettype wire

@@ src/cbm_skid.sv @@
// Two-entry output buffer: result register plus skid register.
`default_nettype none
module cbm_skid (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire cbm_pkg::res_t push_res,
	output logic               full,
	output logic               out_valid,
	input  wire logic          out_stall,
	output cbm_pkg::res_t      out_res
);

	logic          main_v_q, skid_v_q;
	cbm_pkg::res_t main_q, skid_q;
	logic          pop_ok;

	assign full      = skid_v_q;
	assign out_valid = main_v_q;
	assign out_res   = main_q;
	assign pop_ok    = !main_v_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop_ok) begin
			main_v_q <= skid_v_q || push;
			skid_v_q <= 1'b0;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_ok) begin
			main_q <= skid_v_q ? skid_q : push_res;
		end else if (push) begin
			skid_q <= push_res;
		end
	end

endmodule
`default_nettype wire

@@ src/cartridge_bank_mapper_irq_unit.sv @@
// Top level of the cartridge bank mapper with scanline/CPU-cycle IRQ counter.
// Input channel (in_valid / in_stall): one beat is one bus event, chosen by op:
//   CPU write to the mapper window, CPU cycle tick, PPU bus cycle, or lookup only.
//   address feeds the write decode, the program slot, the pattern slot and PPU A12.
// Output channel (out_valid / out_stall): one result beat per input beat, in order:
//   IRQ line, 8 KB program bank, 1 KB pattern bank and mirroring, all taken after
//   the input beat's own effect on the mapper state.
// Result: a taken beat's result is registered, in the skid entry on a stall.
// Throughput: one beat per clock while in_stall is low; the state update and both
//   bank lookups fit between the input ports and the result register.
// Stall: the result register holds while out_stall is high; a skid register takes
//   one more result, and in_stall rises only when that skid entry is occupied.
// Reset (arst_n low): banks go to their power-up values (program banks to the last
//   bank, pattern bank i to i), IRQ counter, prescaler and line clear, both
//   channels empty; in_stall is low right after reset.
`default_nettype none
module cartridge_bank_mapper_irq_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  op,
	input  wire logic [15:0] address,
	input  wire logic [7:0]  data,
	input  wire logic        rendering,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             irq_asserted,
	output logic [7:0]       prg_bank,
	output logic [7:0]       chr_bank,
	output logic             mirror_horizontal
);

	logic          accept;
	cbm_pkg::res_t res_c;
	cbm_pkg::res_t res_q;

	// a valid beat is taken whenever the skid entry is free
	assign accept = in_valid && !in_stall;

	// register file and counter; result is formed from the post-update state
	cbm_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (accept),
		.op       (op),
		.address  (address),
		.data     (data),
		.rendering(rendering),
		.res      (res_c)
	);

	// result register and skid entry decouple a stalled receiver from the input side
	cbm_skid u_skid (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_res (res_c),
		.full     (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_res  (res_q)
	);

	assign irq_asserted      = res_q.irq_asserted;
	assign prg_bank          = res_q.prg_bank;
	assign chr_bank          = res_q.chr_bank;
	assign mirror_horizontal = res_q.mirror_horizontal;

endmodule
`default_nettype wire

@@ src/cbm_checker.sv @@
// Port-level checks for the mapper top level and their bind.
`default_nettype none
module cbm_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic       irq_asserted,
	input wire logic [7:0] prg_bank,
	input wire logic [7:0] chr_bank,
	input wire logic       mirror_horizontal
);

	// backpressure only once a result is already waiting
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("in_stall high with no result pending");

	// out_valid is high in the cycle after every taken beat
	a_beat_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> out_valid)
		else $error("accepted beat produced no result");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(irq_asserted) && $stable(prg_bank) &&
			$stable(chr_bank) && $stable(mirror_horizontal)))
		else $error("result changed while stalled");

endmodule

bind cartridge_bank_mapper_irq_unit cbm_checker u_cbm_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_stall         (in_stall),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.irq_asserted     (irq_asserted),
	.prg_bank         (prg_bank),
	.chr_bank         (chr_bank),
	.mirror_horizontal(mirror_horizontal)
);
`default_nettype wire

@@ tb/cartridge_bank_mapper_irq_unit_test.sv @@
// Self-checking testbench for the cartridge bank mapper with IRQ counter.
`timescale 1ns / 1ps
module cartridge_bank_mapper_irq_unit_test;
	import cbm_pkg::*;

	// bank select code outside the decoded set: data write lands nowhere
	localparam logic [3:0] SEL_UNUSED = 4'd10;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	op_t         op = OP_LOOKUP;
	logic [15:0] address = 16'h0000;
	logic [7:0]  data = 8'h00;
	logic        rendering = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        irq_asserted;
	logic [7:0]  prg_bank;
	logic [7:0]  chr_bank;
	logic        mirror_horizontal;

	cartridge_bank_mapper_irq_unit dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.op               (op),
		.address          (address),
		.data             (data),
		.rendering        (rendering),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.irq_asserted     (irq_asserted),
		.prg_bank         (prg_bank),
		.chr_bank         (chr_bank),
		.mirror_horizontal(mirror_horizontal)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mapper state as the testbench expects it to be.
	logic [7:0] cmd_m;
	logic [7:0] prg_m [3];
	logic [7:0] chr_m [8];
	logic       mirror_m;
	logic       irq_en_m;
	logic [7:0] count_m;
	logic [7:0] latch_m;
	logic       reload_m;
	logic       cpu_mode_m;
	logic [3:0] a12_m;
	logic [2:0] presc_m;
	logic [2:0] delay_m;
	logic       line_m;

	res_t mapping_q [$];   // bank/IRQ views still owed by the DUT, oldest first
	int   errors = 0;
	int   beats_sent = 0;
	bit   steady = 1'b0;   // when set, neither side inserts gaps or stalls
	int   stall_left = 0;

	function automatic void mapper_power_up();
		cmd_m = 8'h00;
		for (int i = 0; i < 3; i++) prg_m[i] = PRG_LAST_BANK;
		for (int i = 0; i < 8; i++) chr_m[i] = 8'(i);
		mirror_m   = 1'b0;
		irq_en_m   = 1'b0;
		count_m    = 8'h00;
		latch_m    = 8'h00;
		reload_m   = 1'b0;
		cpu_mode_m = 1'b0;
		a12_m      = 4'h0;
		presc_m    = 3'd0;
		delay_m    = 3'd0;
		line_m     = 1'b0;
	endfunction

	// Apply one bus event to the expected state, then form the view it produces.
	function automatic res_t step_mapper(op_t o, logic [15:0] a, logic [7:0] d, logic r);
		res_t res;
		logic counter_clk;
		logic [2:0] idx;
		counter_clk = 1'b0;
		case (o)
		OP_CPU_WRITE: begin
			if (a[15]) begin
				case (region_t'(a[14:13]))
				RGN_BANK: begin
					if (!a[0]) begin
						cmd_m = d;
					end else begin
						case (sel_t'(cmd_m[3:0]))
						SEL_CHR0: chr_m[0] = d;
						SEL_CHR2: chr_m[2] = d;
						SEL_CHR4: chr_m[4] = d;
						SEL_CHR5: chr_m[5] = d;
						SEL_CHR6: chr_m[6] = d;
						SEL_CHR7: chr_m[7] = d;
						SEL_PRG0: prg_m[0] = d;
						SEL_PRG1: prg_m[1] = d;
						SEL_CHR1: chr_m[1] = d;
						SEL_CHR3: chr_m[3] = d;
						SEL_PRG2: prg_m[2] = d;
						default: ;
						endcase
					end
				end
				RGN_MIRROR: begin
					if (!a[0]) mirror_m = d[0];
				end
				RGN_IRQ: begin
					if (a[0]) begin
						cpu_mode_m = d[0];
						reload_m   = 1'b1;
						presc_m    = d[0] ? PRESCALE_RELOAD : 3'd0;
					end else begin
						latch_m = d;
					end
				end
				RGN_ACK: begin
					irq_en_m = a[0];
					line_m   = 1'b0;
				end
				endcase
			end
		end
		OP_CPU_TICK: begin
			if (cpu_mode_m) begin
				presc_m = presc_m - 3'd1;
				if (presc_m == 3'd0) begin
					counter_clk = 1'b1;
					presc_m = PRESCALE_RELOAD;
				end
			end else if (presc_m != 3'd0) begin
				presc_m = presc_m - 3'd1;
				if (presc_m == 3'd0) counter_clk = 1'b1;
			end
			if (counter_clk) begin
				if (reload_m) begin
					reload_m = 1'b0;
					count_m = latch_m;
					if (latch_m != 8'h00) count_m[0] = 1'b1;
				end else if (count_m == 8'h00) begin
					count_m = latch_m;
				end else begin
					count_m = count_m - 8'd1;
				end
				if (irq_en_m && count_m == 8'h00) delay_m = ASSERT_DELAY;
			end
			if (delay_m != 3'd0) begin
				delay_m = delay_m - 3'd1;
				if (delay_m == 3'd0) line_m = 1'b1;
			end
		end
		OP_PPU_CYCLE: begin
			if (!cpu_mode_m && r) begin
				if (a12_m != 4'h0) a12_m = a12_m - 4'h1;
				if (a[PPU_A12_BIT]) begin
					// only a rise after the filter has drained clocks the counter
					if (a12_m == 4'h0) presc_m = 3'd1;
					a12_m = A12_HOLD;
				end
			end
		end
		default: ;
		endcase

		res.irq_asserted      = line_m;
		res.mirror_horizontal = mirror_m;
		if (!a[15]) begin
			res.prg_bank = 8'h00;
		end else begin
			case (a[14:13])
			2'd0:    res.prg_bank = cmd_m[CMD_PRG_SWAP_BIT] ? prg_m[2] : prg_m[0];
			2'd1:    res.prg_bank = prg_m[1];
			2'd2:    res.prg_bank = cmd_m[CMD_PRG_SWAP_BIT] ? prg_m[0] : prg_m[2];
			default: res.prg_bank = PRG_LAST_BANK;
			endcase
		end
		if (a >= 16'h2000) begin
			res.chr_bank = 8'h00;
		end else begin
			idx = a[12:10] ^ {cmd_m[CMD_CHR_INV_BIT], 2'b00};
			if (cmd_m[CMD_CHR_1K_BIT] || idx[2])
				res.chr_bank = chr_m[idx];
			else
				res.chr_bank = {chr_m[{1'b0, idx[1], 1'b0}][7:1], idx[0]};
		end
		return res;
	endfunction

	// CPU address inside the mapper window, random in the undecoded bits.
	function automatic logic [15:0] window_addr(region_t rg, logic odd);
		logic [11:0] mid;
		mid = 12'($urandom);
		return {1'b1, rg, mid, odd};
	endfunction

	// Drive one input beat, wait for it to be taken, then log its expected view.
	task automatic send_bus_event(op_t o, logic [15:0] a, logic [7:0] d, logic r);
		int gap;
		if (beats_sent % 32 == 0) steady = ($urandom_range(0, 3) == 0);
		gap = steady ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		op        <= o;
		address   <= a;
		data      <= d;
		rendering <= r;
		do @(posedge clk); while (in_stall);
		mapping_q.push_back(step_mapper(o, a, d, r));
		beats_sent++;
	endtask

	// Result side: compare each taken beat with the oldest expectation and
	// draw a fresh stall length after every beat.
	always @(posedge clk) begin
		res_t want;
		if (out_valid && !out_stall) begin
			if (mapping_q.size() == 0) begin
				$error("result beat with no expected view pending");
				errors++;
			end else begin
				want = mapping_q.pop_front();
				if (irq_asserted !== want.irq_asserted) begin
					$error("irq_asserted: expected %0d, got %0d",
						want.irq_asserted, irq_asserted);
					errors++;
				end
				if (prg_bank !== want.prg_bank) begin
					$error("prg_bank: expected %0d, got %0d", want.prg_bank, prg_bank);
					errors++;
				end
				if (chr_bank !== want.chr_bank) begin
					$error("chr_bank: expected %0d, got %0d", want.chr_bank, chr_bank);
					errors++;
				end
				if (mirror_horizontal !== want.mirror_horizontal) begin
					$error("mirror_horizontal: expected %0d, got %0d",
						want.mirror_horizontal, mirror_horizontal);
					errors++;
				end
			end
			stall_left = steady ? 0 : $urandom_range(0, 8);
		end
		if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Power-up bank values: CPU space below the window, last slot, pattern edges.
	task automatic test_power_up_lookups();
		send_bus_event(OP_LOOKUP, 16'h0000, 8'h00, 1'b0);
		send_bus_event(OP_LOOKUP, 16'h1FFF, 8'hFF, 1'b1);
		send_bus_event(OP_LOOKUP, 16'hFFFF, 8'hA5, 1'b0);
	endtask

	// Command/data pairs, unused select, ignored writes, mirroring.
	task automatic test_bank_registers();
		send_bus_event(OP_CPU_WRITE, 16'h7FFF, 8'hFF, 1'b0);              // below window
		send_bus_event(OP_CPU_WRITE, 16'h8000, {3'b111, 1'b0, SEL_PRG0}, 1'b0);
		send_bus_event(OP_CPU_WRITE, 16'h9FFF, 8'h3C, 1'b1);
		send_bus_event(OP_LOOKUP, 16'hC000, 8'h00, 1'b0);                 // swapped slot
		send_bus_event(OP_CPU_WRITE, 16'h8000, {4'h0, SEL_UNUSED}, 1'b0);
		send_bus_event(OP_CPU_WRITE, 16'h8001, 8'h55, 1'b0);              // lands nowhere
		send_bus_event(OP_CPU_WRITE, 16'hA000, 8'hFF, 1'b0);
		send_bus_event(OP_CPU_WRITE, 16'hA001, 8'h00, 1'b0);              // odd: ignored
		send_bus_event(OP_LOOKUP, 16'h0400, 8'h00, 1'b1);
	endtask

	// PPU clocking: zero latch, one filtered A12 rise, line after the delay, ack.
	task automatic test_ppu_irq();
		send_bus_event(OP_CPU_WRITE, 16'hC000, 8'h00, 1'b0);
		send_bus_event(OP_CPU_WRITE, 16'hC001, 8'h00, 1'b0);
		send_bus_event(OP_CPU_WRITE, 16'hE001, 8'h00, 1'b0);
		send_bus_event(OP_PPU_CYCLE, 16'h1000, 8'h00, 1'b0);              // not rendering
		send_bus_event(OP_PPU_CYCLE, 16'h1000, 8'h00, 1'b1);
		repeat (4) send_bus_event(OP_CPU_TICK, 16'h8000, 8'h00, 1'b0);
		send_bus_event(OP_CPU_WRITE, 16'hE000, 8'h00, 1'b0);
	endtask

	// CPU clocking through the divide-by-4 prescaler.
	task automatic test_cpu_irq();
		send_bus_event(OP_CPU_WRITE, 16'hC001, 8'h01, 1'b0);
		send_bus_event(OP_CPU_WRITE, 16'hE001, 8'h00, 1'b0);
		repeat (8) send_bus_event(OP_CPU_TICK, 16'hE000, 8'h00, 1'b1);
	endtask

	task automatic test_random_bank_traffic(int n);
		int target;
		int pick;
		target = beats_sent + n;
		while (beats_sent < target) begin
			pick = $urandom_range(0, 9);
			if (pick <= 3) begin
				send_bus_event(OP_CPU_WRITE, window_addr(RGN_BANK, 1'b0),
					8'($urandom), 1'($urandom));
				send_bus_event(OP_CPU_WRITE, window_addr(RGN_BANK, 1'b1),
					8'($urandom), 1'($urandom));
			end else if (pick == 4) begin
				send_bus_event(OP_CPU_WRITE, window_addr(RGN_MIRROR, 1'($urandom)),
					8'($urandom), 1'($urandom));
			end else if (pick == 5) begin
				send_bus_event(OP_CPU_WRITE, {1'b0, 15'($urandom)}, 8'($urandom),
					1'($urandom));
			end else begin
				send_bus_event(OP_LOOKUP, 16'($urandom), 8'($urandom), 1'($urandom));
			end
		end
	endtask

	// Scanline-like PPU traffic: A12-low fetches, a rise, then CPU ticks.
	task automatic test_random_scanlines(int n);
		int target;
		logic [15:0] a;
		logic [7:0] d;
		target = beats_sent + n;
		d = 8'($urandom);
		d[0] = 1'b0;
		send_bus_event(OP_CPU_WRITE, window_addr(RGN_IRQ, 1'b1), d, 1'b0);
		send_bus_event(OP_CPU_WRITE, window_addr(RGN_ACK, 1'b1), 8'($urandom), 1'b0);
		while (beats_sent < target) begin
			if ($urandom_range(0, 4) == 0) begin
				case ($urandom_range(0, 2))
				0: send_bus_event(OP_CPU_WRITE, window_addr(RGN_IRQ, 1'b0),
					($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5)),
					1'($urandom));
				1: begin
					d = 8'($urandom);
					d[0] = ($urandom_range(0, 7) == 0);
					send_bus_event(OP_CPU_WRITE, window_addr(RGN_IRQ, 1'b1), d, 1'b1);
				end
				default: send_bus_event(OP_CPU_WRITE,
					window_addr(RGN_ACK, $urandom_range(0, 3) != 0), 8'($urandom), 1'b0);
				endcase
			end
			repeat ($urandom_range(1, 10)) begin
				a = 16'($urandom);
				a[PPU_A12_BIT] = 1'b0;
				send_bus_event(OP_PPU_CYCLE, a, 8'($urandom), $urandom_range(0, 7) != 0);
				if ($urandom_range(0, 3) == 0)
					send_bus_event(OP_CPU_TICK, 16'($urandom), 8'($urandom), 1'($urandom));
			end
			repeat ($urandom_range(1, 3)) begin
				a = 16'($urandom);
				a[PPU_A12_BIT] = 1'b1;
				send_bus_event(OP_PPU_CYCLE, a, 8'($urandom), $urandom_range(0, 7) != 0);
			end
			repeat ($urandom_range(1, 3))
				send_bus_event(OP_CPU_TICK, 16'($urandom), 8'($urandom), 1'($urandom));
		end
	endtask

	// CPU-clocked counter: mostly ticks, with latch writes, acks and stray PPU bus events.
	task automatic test_random_cpu_clocking(int n);
		int target;
		logic [7:0] d;
		target = beats_sent + n;
		d = 8'($urandom);
		d[0] = 1'b1;
		send_bus_event(OP_CPU_WRITE, window_addr(RGN_IRQ, 1'b0), 8'($urandom_range(0, 3)),
			1'b0);
		send_bus_event(OP_CPU_WRITE, window_addr(RGN_IRQ, 1'b1), d, 1'b0);
		send_bus_event(OP_CPU_WRITE, window_addr(RGN_ACK, 1'b1), 8'($urandom), 1'b0);
		while (beats_sent < target) begin
			case ($urandom_range(0, 9))
			0: send_bus_event(OP_CPU_WRITE, window_addr(RGN_ACK, 1'($urandom)),
				8'($urandom), 1'b0);
			1: send_bus_event(OP_CPU_WRITE, window_addr(RGN_IRQ, 1'b0),
				8'($urandom_range(0, 4)), 1'b0);
			2: send_bus_event(OP_PPU_CYCLE, 16'($urandom), 8'($urandom), 1'($urandom));
			default: send_bus_event(OP_CPU_TICK, 16'($urandom), 8'($urandom),
				1'($urandom));
			endcase
		end
	endtask

	task automatic test_random_noise(int n);
		repeat (n)
			send_bus_event(op_t'(2'($urandom)), 16'($urandom), 8'($urandom), 1'($urandom));
	endtask

	initial begin
		int drain;
		mapper_power_up();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_power_up_lookups();
		test_bank_registers();
		test_ppu_irq();
		test_cpu_irq();
		test_random_bank_traffic(170);
		test_random_scanlines(250);
		test_random_cpu_clocking(70);
		test_random_noise(60);
		in_valid <= 1'b0;

		// result register plus skid entry: wait for the expected queue to empty, up to a bound
		drain = 0;
		while (mapping_q.size() != 0 && drain < 2000) begin
			@(posedge clk);
			drain++;
		end
		repeat (8) @(posedge clk);
		if (mapping_q.size() != 0) begin
			$error("%0d expected result beats never arrived", mapping_q.size());
			errors++;
		end
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
